/* rtl/core/misra_gries_heavy_hitters_top_macros.svh */
// assertion macros for the frequent-items summary checker
`ifndef MISRA_GRIES_HEAVY_HITTERS_TOP_MACROS_SVH
`define MISRA_GRIES_HEAVY_HITTERS_TOP_MACROS_SVH

// implication checked outside reset
`define MGH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// implication checked through reset as well
`define MGH_ASSERT_ALL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/mgh_pkg.sv */
// shared types and constants of the frequent-items summary
`default_nettype none
package mgh_pkg;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_BITS     = 5;
    localparam int MAX_RESULTS  = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_CAP  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_TOPK = 2'd1;
    localparam logic [CFG_BITS-1:0]     CAP_RESET    = 5'd16;
    localparam logic [CFG_BITS-1:0]     TOPK_RESET   = 5'd8;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_REPORT = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_DECR
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_key_en;
    } t_mem_ctl;
endpackage
`default_nettype wire

/* rtl/core/misra_gries_heavy_hitters_top.sv */
// frequent-items summary: slot memories, sequencer and configuration registers
// each command scans all SLOTS entries through the single memory read port
// query: one result once the scan is done; no new request is taken while busy
// update: one scan, plus a second scan when every counter is decremented
// report: one full scan per entry; results cannot be stalled
// synchronous reset empties the summary and restores capacity 16, top_k 8
`default_nettype none
module misra_gries_heavy_hitters_top #(
    parameter int SLOTS      = 16,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire  [1:0]                          i_cmd,
    input  wire  [KEY_BITS-1:0]                 i_key,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [mgh_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire  [mgh_pkg::CFG_BITS-1:0]        i_cfg_data,
    output logic                                o_strobe,
    output logic [KEY_BITS-1:0]                 o_out_key,
    output logic [COUNT_BITS-1:0]               o_out_count,
    output logic                                o_last
);
    import mgh_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [CFG_BITS-1:0]   r_cap;
    logic [CFG_BITS-1:0]   r_topk;
    t_mem_ctl              mem_ctl;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [KEY_BITS-1:0]   wr_key;
    logic [COUNT_BITS-1:0] wr_cnt;
    logic [KEY_BITS-1:0]   rd_key;
    logic [COUNT_BITS-1:0] rd_cnt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_RESET;
            r_topk <= TOPK_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IDX_CAP) begin
                r_cap <= i_cfg_data;
            end
            if (i_cfg_index == CFG_IDX_TOPK) begin
                r_topk <= i_cfg_data;
            end
        end
    end

    mgh_mem #(
        .SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .COUNT_BITS(COUNT_BITS), .AW(AW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mem_ctl),
        .i_rd_addr(rd_addr),
        .i_wr_addr(wr_addr),
        .i_wr_key (wr_key),
        .i_wr_cnt (wr_cnt),
        .o_rd_key (rd_key),
        .o_rd_cnt (rd_cnt)
    );

    mgh_ctrl #(
        .SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .COUNT_BITS(COUNT_BITS), .AW(AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_cmd      (i_cmd),
        .i_key      (i_key),
        .i_cap      (r_cap),
        .i_topk     (r_topk),
        .busy       (busy),
        .o_ctl      (mem_ctl),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr),
        .o_wr_key   (wr_key),
        .o_wr_cnt   (wr_cnt),
        .i_rd_key   (rd_key),
        .i_rd_cnt   (rd_cnt),
        .o_strobe   (o_strobe),
        .o_out_key  (o_out_key),
        .o_out_count(o_out_count),
        .o_last     (o_last)
    );
endmodule
`default_nettype wire

/* rtl/core/mgh_mem.sv */
// slot key and count memories with per-slot valid bits
`default_nettype none
module mgh_mem #(
    parameter int SLOTS      = 16,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 32,
    parameter int AW         = 4
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  mgh_pkg::t_mem_ctl     i_ctl,
    input  wire  [AW-1:0]         i_rd_addr,
    input  wire  [AW-1:0]         i_wr_addr,
    input  wire  [KEY_BITS-1:0]   i_wr_key,
    input  wire  [COUNT_BITS-1:0] i_wr_cnt,
    output logic [KEY_BITS-1:0]   o_rd_key,
    output logic [COUNT_BITS-1:0] o_rd_cnt
);
    import mgh_pkg::*;

    logic [KEY_BITS-1:0]   r_key_mem [SLOTS];
    logic [COUNT_BITS-1:0] r_cnt_mem [SLOTS];
    logic [SLOTS-1:0]      r_valid;
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [COUNT_BITS-1:0] r_rd_cnt;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_cnt_mem[i_wr_addr] <= i_wr_cnt;
            if (i_ctl.wr_key_en) begin
                r_key_mem[i_wr_addr] <= i_wr_key;
            end
        end
        if (i_ctl.rd_en) begin
            r_rd_key <= r_key_mem[i_rd_addr];
            r_rd_cnt <= r_cnt_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    // never-written slot reads as empty
    assign o_rd_key = r_rd_key;
    assign o_rd_cnt = r_rd_vld ? r_rd_cnt : '0;
endmodule
`default_nettype wire

/* rtl/core/mgh_ctrl.sv */
// sequencer: slot scans, insert/increment/decrement and result generation
`default_nettype none
module mgh_ctrl #(
    parameter int SLOTS      = 16,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 32,
    parameter int AW         = 4
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    input  wire  [1:0]                     i_cmd,
    input  wire  [KEY_BITS-1:0]            i_key,
    input  wire  [mgh_pkg::CFG_BITS-1:0]   i_cap,
    input  wire  [mgh_pkg::CFG_BITS-1:0]   i_topk,
    output logic                           busy,
    output mgh_pkg::t_mem_ctl              o_ctl,
    output logic [AW-1:0]                  o_rd_addr,
    output logic [AW-1:0]                  o_wr_addr,
    output logic [KEY_BITS-1:0]            o_wr_key,
    output logic [COUNT_BITS-1:0]          o_wr_cnt,
    input  wire  [KEY_BITS-1:0]            i_rd_key,
    input  wire  [COUNT_BITS-1:0]          i_rd_cnt,
    output logic                           o_strobe,
    output logic [KEY_BITS-1:0]            o_out_key,
    output logic [COUNT_BITS-1:0]          o_out_count,
    output logic                           o_last
);
    import mgh_pkg::*;

    localparam int IW = $clog2(SLOTS + 1);
    localparam int LW = ((IW > CFG_BITS) ? IW : CFG_BITS) + 1;
    localparam logic [IW-1:0] SLOTS_I = IW'(SLOTS);
    localparam logic [LW-1:0] SLOTS_L = LW'(SLOTS);
    localparam logic [LW-1:0] MAXR_L  = LW'(MAX_RESULTS);

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [IW-1:0]         r_idx, n_idx;
    logic [IW-1:0]         r_used, n_used;
    logic                  r_free_found, n_free_found;
    logic [AW-1:0]         r_free, n_free;
    logic                  r_hit_found, n_hit_found;
    logic [AW-1:0]         r_hit, n_hit;
    logic [COUNT_BITS-1:0] r_hit_cnt, n_hit_cnt;
    logic                  r_best_found, n_best_found;
    logic [AW-1:0]         r_best, n_best;
    logic [COUNT_BITS-1:0] r_best_cnt, n_best_cnt;
    logic [KEY_BITS-1:0]   r_best_key, n_best_key;
    logic [SLOTS-1:0]      r_taken, n_taken;
    logic [LW-1:0]         r_n, n_n;
    logic                  r_strobe, n_strobe;
    logic [KEY_BITS-1:0]   r_out_key, n_out_key;
    logic [COUNT_BITS-1:0] r_out_count, n_out_count;
    logic                  r_last, n_last;

    logic [IW-1:0]         s_idx;
    logic [AW-1:0]         s;
    logic                  occ;
    logic [LW-1:0]         cap_l, topk_l, eff_cap, lim, lim_used, used_l;

    // effective capacity and report length
    always_comb begin
        cap_l  = LW'(i_cap);
        topk_l = LW'(i_topk);
        used_l = LW'(r_used);
        if (cap_l == '0) begin
            eff_cap = LW'(1);
        end else if (cap_l > SLOTS_L) begin
            eff_cap = SLOTS_L;
        end else begin
            eff_cap = cap_l;
        end
        lim = (topk_l == '0) ? LW'(1) : topk_l;
        if (lim > eff_cap) begin
            lim = eff_cap;
        end
        if (lim > MAXR_L) begin
            lim = MAXR_L;
        end
        lim_used = (lim < used_l) ? lim : used_l;
    end

    assign s_idx = r_idx - IW'(1);
    assign s     = s_idx[AW-1:0];
    assign occ   = (i_rd_cnt != '0);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_idx        = r_idx;
        n_used       = r_used;
        n_free_found = r_free_found;
        n_free       = r_free;
        n_hit_found  = r_hit_found;
        n_hit        = r_hit;
        n_hit_cnt    = r_hit_cnt;
        n_best_found = r_best_found;
        n_best       = r_best;
        n_best_cnt   = r_best_cnt;
        n_best_key   = r_best_key;
        n_taken      = r_taken;
        n_n          = r_n;
        n_strobe     = 1'b0;
        n_out_key    = r_out_key;
        n_out_count  = r_out_count;
        n_last       = r_last;
        o_ctl        = '0;
        o_rd_addr    = r_idx[AW-1:0];
        o_wr_addr    = s;
        o_wr_key     = r_key;
        o_wr_cnt     = i_rd_cnt - COUNT_BITS'(1);

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_key   = i_key;
                    n_taken = '0;
                    n_n     = '0;
                    if (t_cmd'(i_cmd) != CMD_NONE) begin
                        n_state      = ST_SCAN;
                        n_idx        = '0;
                        n_used       = '0;
                        n_free_found = 1'b0;
                        n_hit_found  = 1'b0;
                        n_best_found = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                o_ctl.rd_en = (r_idx < SLOTS_I);
                // read data belongs to the slot addressed in the previous cycle
                if (r_idx != '0) begin
                    if (occ) begin
                        n_used = r_used + IW'(1);
                    end else if (!r_free_found) begin
                        n_free_found = 1'b1;
                        n_free       = s;
                    end
                    if (!r_hit_found && occ && i_rd_key == r_key) begin
                        n_hit_found = 1'b1;
                        n_hit       = s;
                        n_hit_cnt   = i_rd_cnt;
                    end
                    if (occ && !r_taken[s] && (!r_best_found || i_rd_cnt > r_best_cnt)) begin
                        n_best_found = 1'b1;
                        n_best       = s;
                        n_best_cnt   = i_rd_cnt;
                        n_best_key   = i_rd_key;
                    end
                end
                if (r_idx == SLOTS_I) begin
                    n_state = ST_EVAL;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_EVAL: begin
                n_state = ST_IDLE;
                priority case (r_cmd)
                    CMD_UPDATE: begin
                        if (r_hit_found) begin
                            o_ctl.wr_en = 1'b1;
                            o_wr_addr   = r_hit;
                            o_wr_cnt    = (r_hit_cnt == '1) ? r_hit_cnt
                                                            : r_hit_cnt + COUNT_BITS'(1);
                        end else if (used_l < eff_cap && r_free_found) begin
                            o_ctl.wr_en     = 1'b1;
                            o_ctl.wr_key_en = 1'b1;
                            o_wr_addr       = r_free;
                            o_wr_cnt        = COUNT_BITS'(1);
                        end else begin
                            n_state = ST_DECR;
                            n_idx   = '0;
                        end
                    end
                    CMD_QUERY: begin
                        n_strobe    = 1'b1;
                        n_out_key   = r_key;
                        n_out_count = r_hit_found ? r_hit_cnt : '0;
                        n_last      = 1'b1;
                    end
                    CMD_REPORT: begin
                        n_strobe = 1'b1;
                        if (!r_best_found) begin
                            // empty summary
                            n_out_key   = '0;
                            n_out_count = '0;
                            n_last      = 1'b1;
                        end else begin
                            n_out_key       = r_best_key;
                            n_out_count     = r_best_cnt;
                            n_taken[r_best] = 1'b1;
                            n_n             = r_n + LW'(1);
                            n_last          = ((r_n + LW'(1)) >= lim_used);
                            if ((r_n + LW'(1)) < lim_used) begin
                                n_state      = ST_SCAN;
                                n_idx        = '0;
                                n_used       = '0;
                                n_free_found = 1'b0;
                                n_hit_found  = 1'b0;
                                n_best_found = 1'b0;
                            end
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_DECR: begin
                o_ctl.rd_en = (r_idx < SLOTS_I);
                // write back slot k-1 while reading slot k
                if (r_idx != '0 && occ) begin
                    o_ctl.wr_en = 1'b1;
                end
                if (r_idx == SLOTS_I) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_used       <= n_used;
        r_free_found <= n_free_found;
        r_free       <= n_free;
        r_hit_found  <= n_hit_found;
        r_hit        <= n_hit;
        r_hit_cnt    <= n_hit_cnt;
        r_best_found <= n_best_found;
        r_best       <= n_best;
        r_best_cnt   <= n_best_cnt;
        r_best_key   <= n_best_key;
        r_taken      <= n_taken;
        r_n          <= n_n;
        r_out_key    <= n_out_key;
        r_out_count  <= n_out_count;
        r_last       <= n_last;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_strobe    = r_strobe;
    assign o_out_key   = r_out_key;
    assign o_out_count = r_out_count;
    assign o_last      = r_last;
endmodule
`default_nettype wire

/* rtl/core/mgh_checker.sv */
// port-level checks of the frequent-items summary, bound to the top level
`default_nettype none
`include "misra_gries_heavy_hitters_top_macros.svh"
module mgh_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       start,
    input wire       busy,
    input wire [1:0] i_cmd,
    input wire       o_strobe
);
    import mgh_pkg::*;

    logic accept;
    assign accept = start && !busy;

    `MGH_ASSERT_IMP(a_cmd_goes_busy, accept && i_cmd != CMD_NONE, busy)
    `MGH_ASSERT_IMP(a_no_result_after_request, accept, !o_strobe)
    `MGH_ASSERT_IMP(a_results_spaced, o_strobe, !o_strobe)
    `MGH_ASSERT_ALL(a_reset_idle, !i_rst_n, !busy && !o_strobe)
endmodule

bind misra_gries_heavy_hitters_top mgh_checker u_mgh_checker (.*);
`default_nettype wire
